// File: sv/gudd_pkg.sv
package gudd_pkg;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_X     = 8'h58;
	localparam logic [7:0] CH_Y     = 8'h59;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_V     = 8'h56;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;

	localparam logic [7:0] GAIN_RESET = 8'd50;
	localparam logic [7:0] AXIS_RESET = 8'd127;
	localparam logic [9:0] AXIS_SUM_MID = 10'd254;

	localparam logic REG_DRIVE_GAIN = 1'b0;

	typedef struct packed {
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
	} cmd_t;

	typedef struct packed {
		logic signed [17:0] speed_left;
		logic signed [17:0] speed_right;
		logic               pump_on;
		logic               valve_on;
		logic               gripper_on;
		logic               servo_sel;
	} out_item_t;

endpackage

// File: sv/gudd_fifo.sv
module gudd_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/gudd_front.sv
module gudd_front #(
	parameter int FRAME_MAX = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_beat,
	input  logic [7:0]      rx_byte,
	output logic            cmd_push,
	output gudd_pkg::cmd_t  cmd
);

	localparam int FW = $clog2(FRAME_MAX);

	logic [FW-1:0] fill_q;
	logic [7:0]    byte_q [3];
	logic [7:0]    cur    [3];
	logic          frame_end;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cur[i] = (fill_q == FW'(i)) ? rx_byte : byte_q[i];
		end
	end

	assign frame_end = (rx_byte == gudd_pkg::CH_LF) || (fill_q == FW'(FRAME_MAX - 1));
	assign cmd_push  = in_beat && frame_end;
	assign cmd.c0    = cur[0];
	assign cmd.c1    = cur[1];
	assign cmd.c2    = cur[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < 3; i++) begin
				byte_q[i] <= '0;
			end
		end else if (in_beat) begin
			for (int i = 0; i < 3; i++) begin
				byte_q[i] <= cur[i];
			end
			fill_q <= frame_end ? '0 : fill_q + 1'b1;
		end
	end

endmodule

// File: sv/gudd_back.sv
module gudd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  gudd_pkg::cmd_t      cmd,
	input  logic [7:0]          drive_gain,
	input  logic                out_full,
	output logic                cmd_pop,
	output gudd_pkg::out_item_t item
);

	logic [7:0] axis_x_q, axis_y_q;
	logic       boost_q, pump_q, valve_q, grip_q, servo_q;
	logic [7:0] nx, ny;
	logic       nboost, npump, nvalve, ngrip, nservo;
	logic signed [9:0]  diff_l, diff_r, mult;
	logic signed [17:0] prod_l, prod_r;

	assign cmd_pop = cmd_valid && !out_full;

	always_comb begin
		nx     = axis_x_q;
		ny     = axis_y_q;
		nboost = boost_q;
		npump  = pump_q;
		nvalve = valve_q;
		ngrip  = grip_q;
		nservo = servo_q;
		if (cmd.c0 == gudd_pkg::CH_B) begin
			case (cmd.c1)
				gudd_pkg::CH_X: begin
					if (cmd.c2 == gudd_pkg::CH_ZERO) ngrip = 1'b0;
					else if (cmd.c2 == gudd_pkg::CH_ONE) ngrip = 1'b1;
				end
				gudd_pkg::CH_HASH: begin
					if (cmd.c2 == gudd_pkg::CH_ZERO) nservo = 1'b0;
					else if (cmd.c2 == gudd_pkg::CH_ONE) nservo = 1'b1;
				end
				gudd_pkg::CH_O: begin
					if (cmd.c2 == gudd_pkg::CH_ZERO) begin
						nvalve = 1'b1;
					end else if (cmd.c2 == gudd_pkg::CH_ONE) begin
						npump  = 1'b1;
						nvalve = 1'b0;
					end
				end
				gudd_pkg::CH_V: begin
					if (cmd.c2 == gudd_pkg::CH_ONE) npump = !pump_q;
				end
				gudd_pkg::CH_R: begin
					if (cmd.c2 == gudd_pkg::CH_ZERO) nboost = 1'b0;
					else if (cmd.c2 == gudd_pkg::CH_ONE) nboost = 1'b1;
				end
				default: ;
			endcase
		end else if (cmd.c0 == gudd_pkg::CH_L) begin
			case (cmd.c1)
				gudd_pkg::CH_X: nx = cmd.c2;
				gudd_pkg::CH_Y: ny = cmd.c2;
				default: ;
			endcase
		end
	end

	always_comb begin
		diff_l = signed'({2'b00, nx}) - signed'({2'b00, ny});
		diff_r = signed'(gudd_pkg::AXIS_SUM_MID) - signed'({2'b00, nx})
			- signed'({2'b00, ny});
		mult   = nboost ? signed'({1'b0, drive_gain, 1'b0}) : signed'({2'b00, drive_gain});
		prod_l = 18'(diff_l) * 18'(mult);
		prod_r = 18'(diff_r) * 18'(mult);
	end

	assign item.speed_left  = prod_l;
	assign item.speed_right = prod_r;
	assign item.pump_on     = npump;
	assign item.valve_on    = nvalve;
	assign item.gripper_on  = ngrip;
	assign item.servo_sel   = nservo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_x_q <= gudd_pkg::AXIS_RESET;
			axis_y_q <= gudd_pkg::AXIS_RESET;
			boost_q  <= 1'b0;
			pump_q   <= 1'b1;
			valve_q  <= 1'b0;
			grip_q   <= 1'b0;
			servo_q  <= 1'b0;
		end else if (cmd_pop) begin
			axis_x_q <= nx;
			axis_y_q <= ny;
			boost_q  <= nboost;
			pump_q   <= npump;
			valve_q  <= nvalve;
			grip_q   <= ngrip;
			servo_q  <= nservo;
		end
	end

endmodule

// File: sv/gamepad_uart_drive_decoder_top.sv
// channel   direction  handshake               payload
// bytes     in         push / full             rx_byte
// results   out        pop / empty             speed_left, speed_right, pump_on,
//                                              valve_on, gripper_on, servo_sel
// config    in         APB psel/penable/pready drive_gain at byte address 0
//
// One byte a cycle while full is low; a frame-ending byte pushes its command into the command queue,
// and the decoder moves it on into the result queue when that queue has room.
// The command queue and the result queue are two beats deep each.
// full follows the command queue, empty follows the result queue.
// arst_n clears the frame buffer, axes to 127, pump on, gain to 50.
module gamepad_uart_drive_decoder_top #(
	parameter int FRAME_MAX = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         rx_byte,
	output logic               empty,
	input  logic               pop,
	output logic signed [17:0] speed_left,
	output logic signed [17:0] speed_right,
	output logic               pump_on,
	output logic               valve_on,
	output logic               gripper_on,
	output logic               servo_sel,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int CMD_W = $bits(gudd_pkg::cmd_t);
	localparam int OUT_W = $bits(gudd_pkg::out_item_t);

	logic                in_beat;
	logic                cmd_push, cmd_full, cmd_empty, cmd_pop;
	gudd_pkg::cmd_t      cmd_in, cmd_out;
	gudd_pkg::out_item_t item_in, item_out;
	logic                out_full;
	logic [7:0]          gain_q;

	assign pready  = 1'b1;
	assign full    = cmd_full;
	assign in_beat = push && !cmd_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= gudd_pkg::GAIN_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == gudd_pkg::REG_DRIVE_GAIN) begin
			gain_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == gudd_pkg::REG_DRIVE_GAIN) ? {24'd0, gain_q} : 32'd0;

	gudd_front #(.FRAME_MAX(FRAME_MAX)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_beat  (in_beat),
		.rx_byte  (rx_byte),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	gudd_fifo #(.W(CMD_W), .DEPTH(2)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	gudd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (!cmd_empty),
		.cmd        (cmd_out),
		.drive_gain (gain_q),
		.out_full   (out_full),
		.cmd_pop    (cmd_pop),
		.item       (item_in)
	);

	gudd_fifo #(.W(OUT_W), .DEPTH(2)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_pop),
		.wdata  (item_in),
		.full   (out_full),
		.pop    (pop),
		.rdata  (item_out),
		.empty  (empty)
	);

	assign speed_left  = item_out.speed_left;
	assign speed_right = item_out.speed_right;
	assign pump_on     = item_out.pump_on;
	assign valve_on    = item_out.valve_on;
	assign gripper_on  = item_out.gripper_on;
	assign servo_sel   = item_out.servo_sel;

endmodule

// File: bench/tb_gamepad_uart_drive_decoder_top.sv
`timescale 1ns / 1ps

module tb_gamepad_uart_drive_decoder_top;

	localparam int FRAME_MAX = 5;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [2:0] GAIN_ADDR = 3'(4 * int'(gudd_pkg::REG_DRIVE_GAIN));

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [7:0] rx_byte = 8'h00;
	logic empty;
	logic pop = 1'b0;
	logic signed [17:0] speed_left;
	logic signed [17:0] speed_right;
	logic pump_on;
	logic valve_on;
	logic gripper_on;
	logic servo_sel;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic pready;

	gamepad_uart_drive_decoder_top #(
		.FRAME_MAX(FRAME_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.speed_left(speed_left),
		.speed_right(speed_right),
		.pump_on(pump_on),
		.valve_on(valve_on),
		.gripper_on(gripper_on),
		.servo_sel(servo_sel),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic [7:0] frame_buf [0:7];
	logic [2:0] fill_cnt;
	logic [7:0] axis_x_now;
	logic [7:0] axis_y_now;
	logic boost_now;
	logic pump_now;
	logic valve_now;
	logic grip_now;
	logic servo_now;
	logic [7:0] gain_now;

	logic [7:0] pending_bytes [$];
	gudd_pkg::out_item_t expected_frames [$];

	int fail_count = 0;
	int bytes_queued = 0;
	int bytes_done = 0;
	int frames_checked = 0;
	int gain_settings = 0;
	int idle_cycles = 0;
	int send_hold = 0;
	int pop_hold = 0;
	bit byte_taken = 1'b0;
	bit result_taken = 1'b0;
	bit no_gaps = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic reset_drive_state();
		for (int i = 0; i < 8; i++)
			frame_buf[i] = 8'h00;
		fill_cnt = 3'd0;
		axis_x_now = gudd_pkg::AXIS_RESET;
		axis_y_now = gudd_pkg::AXIS_RESET;
		boost_now = 1'b0;
		pump_now = 1'b1;
		valve_now = 1'b0;
		grip_now = 1'b0;
		servo_now = 1'b0;
		gain_now = gudd_pkg::GAIN_RESET;
	endtask

	task automatic decode_command();
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
		c0 = frame_buf[0];
		c1 = frame_buf[1];
		c2 = frame_buf[2];
		if (c0 == gudd_pkg::CH_B) begin
			if (c1 == gudd_pkg::CH_X) begin
				if (c2 == gudd_pkg::CH_ZERO)
					grip_now = 1'b0;
				else if (c2 == gudd_pkg::CH_ONE)
					grip_now = 1'b1;
			end else if (c1 == gudd_pkg::CH_HASH) begin
				if (c2 == gudd_pkg::CH_ZERO)
					servo_now = 1'b0;
				else if (c2 == gudd_pkg::CH_ONE)
					servo_now = 1'b1;
			end else if (c1 == gudd_pkg::CH_O) begin
				if (c2 == gudd_pkg::CH_ZERO) begin
					valve_now = 1'b1;
				end else if (c2 == gudd_pkg::CH_ONE) begin
					pump_now = 1'b1;
					valve_now = 1'b0;
				end
			end else if (c1 == gudd_pkg::CH_V) begin
				if (c2 == gudd_pkg::CH_ONE)
					pump_now = ~pump_now;
			end else if (c1 == gudd_pkg::CH_R) begin
				if (c2 == gudd_pkg::CH_ZERO)
					boost_now = 1'b0;
				else if (c2 == gudd_pkg::CH_ONE)
					boost_now = 1'b1;
			end
		end else if (c0 == gudd_pkg::CH_L) begin
			if (c1 == gudd_pkg::CH_X)
				axis_x_now = c2;
			else if (c1 == gudd_pkg::CH_Y)
				axis_y_now = c2;
		end
	endtask

	task automatic drive_frame_step(input logic [7:0] b);
		int slot;
		int mult;
		int lft;
		int rgt;
		gudd_pkg::out_item_t r;
		slot = fill_cnt;
		frame_buf[slot] = b;
		if (b != gudd_pkg::CH_LF && slot < FRAME_MAX - 1) begin
			fill_cnt = 3'(slot + 1);
			return;
		end
		fill_cnt = 3'd0;
		decode_command();
		mult = int'(gain_now) * (boost_now ? 2 : 1);
		lft = (int'(axis_x_now) - int'(axis_y_now)) * mult;
		rgt = (int'(gudd_pkg::AXIS_SUM_MID) - int'(axis_x_now) - int'(axis_y_now)) * mult;
		r.speed_left = 18'(lft);
		r.speed_right = 18'(rgt);
		r.pump_on = pump_now;
		r.valve_on = valve_now;
		r.gripper_on = grip_now;
		r.servo_sel = servo_now;
		expected_frames.push_back(r);
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : watch_ports
		gudd_pkg::out_item_t want;
		byte_taken = arst_n && push && !full;
		result_taken = arst_n && pop && !empty;
		if (result_taken) begin
			if (expected_frames.size() == 0) begin
				fail_count++;
				$display("%0t: result beat with nothing expected, got left %0d right %0d",
					$time, speed_left, speed_right);
			end else begin
				want = expected_frames.pop_front();
				check_field("speed_left", want.speed_left, speed_left);
				check_field("speed_right", want.speed_right, speed_right);
				check_field("pump_on", want.pump_on, pump_on);
				check_field("valve_on", want.valve_on, valve_on);
				check_field("gripper_on", want.gripper_on, gripper_on);
				check_field("servo_sel", want.servo_sel, servo_sel);
				frames_checked++;
			end
		end
		if (byte_taken) begin
			drive_frame_step(rx_byte);
			bytes_done++;
		end
		if (byte_taken || result_taken)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, idle_cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk) begin : drive_bytes
		logic next_push;
		logic [7:0] next_byte;
		next_push = 1'b0;
		next_byte = 8'($urandom);
		if (byte_taken) begin
			void'(pending_bytes.pop_front());
			send_hold = gap_len();
		end
		if (arst_n && send_hold > 0) begin
			send_hold--;
		end else if (arst_n && pending_bytes.size() > 0) begin
			next_push = 1'b1;
			next_byte = pending_bytes[0];
		end
		push <= next_push;
		rx_byte <= next_byte;
	end

	always @(negedge clk) begin : drive_pop
		logic next_pop;
		if (result_taken)
			pop_hold = gap_len();
		if (pop_hold > 0) begin
			next_pop = 1'b0;
			pop_hold--;
		end else begin
			next_pop = 1'b1;
		end
		pop <= next_pop;
	end

	task automatic queue_byte(input logic [7:0] b);
		pending_bytes.push_back(b);
		bytes_queued++;
	endtask

	task automatic queue_command(input logic [7:0] c0, input logic [7:0] c1,
		input logic [7:0] c2);
		queue_byte(c0);
		queue_byte(c1);
		queue_byte(c2);
		queue_byte(gudd_pkg::CH_LF);
	endtask

	task automatic queue_random_traffic(input int goal);
		int kind;
		int n;
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
		while (bytes_queued < goal) begin
			if ($urandom_range(0, 99) < 78) begin
				kind = $urandom_range(0, 6);
				c0 = (kind >= 5) ? gudd_pkg::CH_L : gudd_pkg::CH_B;
				case (kind)
					0: c1 = gudd_pkg::CH_X;
					1: c1 = gudd_pkg::CH_HASH;
					2: c1 = gudd_pkg::CH_O;
					3: c1 = gudd_pkg::CH_V;
					4: c1 = gudd_pkg::CH_R;
					5: c1 = gudd_pkg::CH_X;
					default: c1 = gudd_pkg::CH_Y;
				endcase
				if (kind >= 5)
					c2 = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
						: 8'($urandom);
				else if ($urandom_range(0, 99) < 85)
					c2 = $urandom_range(0, 1) ? gudd_pkg::CH_ONE : gudd_pkg::CH_ZERO;
				else
					c2 = 8'($urandom);
				queue_byte(c0);
				queue_byte(c1);
				queue_byte(c2);
				if ($urandom_range(0, 99) < 80) begin
					queue_byte(gudd_pkg::CH_LF);
				end else begin
					queue_byte(8'($urandom));
					queue_byte(8'($urandom));
				end
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					queue_byte(($urandom_range(0, 9) == 0) ? gudd_pkg::CH_LF : 8'($urandom));
				if ($urandom_range(0, 1))
					queue_byte(gudd_pkg::CH_LF);
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() > 0 || expected_frames.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [7:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= GAIN_ADDR;
		pwdata <= {24'd0, wdata};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_gain_readback();
		logic [31:0] rd;
		apb_access(1'b0, 8'd0, rd);
		if (rd !== {24'd0, gain_now}) begin
			fail_count++;
			$display("%0t: drive_gain readback expected %0d, got %0d", $time, gain_now, rd);
		end
	endtask

	task automatic set_gain(input logic [7:0] g);
		logic [31:0] rd;
		apb_access(1'b1, g, rd);
		gain_now = g;
		gain_settings++;
		check_gain_readback();
	endtask

	initial begin
		reset_drive_state();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		check_gain_readback();
		gain_settings++;
		queue_byte(gudd_pkg::CH_LF);
		queue_command(gudd_pkg::CH_L, gudd_pkg::CH_X, 8'hFF);
		queue_command(gudd_pkg::CH_L, gudd_pkg::CH_Y, 8'h00);
		queue_command(gudd_pkg::CH_B, gudd_pkg::CH_R, gudd_pkg::CH_ONE);
		queue_command(gudd_pkg::CH_B, gudd_pkg::CH_O, gudd_pkg::CH_ZERO);
		queue_command(gudd_pkg::CH_B, gudd_pkg::CH_V, gudd_pkg::CH_ONE);
		queue_byte(gudd_pkg::CH_L);
		queue_byte(gudd_pkg::CH_X);
		queue_byte(8'h00);
		queue_byte(8'h80);
		queue_byte(8'h7F);
		wait_drained();

		set_gain(8'd255);
		queue_random_traffic(bytes_queued + 480);
		wait_drained();

		set_gain(8'd0);
		queue_random_traffic(bytes_queued + 400);
		wait_drained();

		set_gain(8'($urandom_range(2, 254)));
		queue_random_traffic(bytes_queued + 520);
		wait_drained();

		no_gaps = 1'b1;
		set_gain(8'd1);
		queue_random_traffic(bytes_queued + 250);
		wait_drained();

		no_gaps = 1'b0;
		set_gain(8'($urandom_range(2, 254)));
		queue_random_traffic(bytes_queued + 250);
		wait_drained();

		$display("Sent %0d bytes, checked %0d frames over %0d gain settings",
			bytes_done, frames_checked, gain_settings);
		$display("Covered every button and joystick command, short and full frames, noise");
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
